// ===== hw/rtl/stia_pkg.sv =====
// ----------------------------------------------------------------------------
// stia_pkg
// Shared types and codes of the symbol table with index allocation.
// ----------------------------------------------------------------------------
`default_nettype none

package stia_pkg;

  // field widths fixed by the interface
  localparam int ACT_W    = 2;
  localparam int KEY_W    = 64;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;

  // default sizing
  localparam int ENTRIES_DEF  = 64;
  localparam int KEY_BITS_DEF = 64;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_DECLARE = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_FULL       = 3'd2,
    ST_UNDECLARED = 3'd3,
    ST_WRONG_KIND = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/symbol_table_with_index_allocation.sv =====
// ----------------------------------------------------------------------------
// symbol_table_with_index_allocation
// Symbol table with linear search and per-kind register index allocation.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Clear and the
// unused action code give their result in the cycle after the accept. Declare
// and query scan the live entries through the single read port of the entry
// memory, one entry per cycle: a hit shows its result after its slot has been
// read and compared, a miss after every live entry has been read and compared.
// busy stays high during the scan. Each result is shown on the out_ ports for
// one cycle with out_valid high and cannot be held off; a new transaction may
// be taken in that same cycle. No clearing pass is needed after reset.
`default_nettype none

module symbol_table_with_index_allocation #(
  parameter int ENTRIES  = stia_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = stia_pkg::KEY_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [stia_pkg::ACT_W-1:0]     in_action,
  input  wire logic [stia_pkg::KEY_W-1:0]     in_name_key,
  input  wire logic                           in_kind,
  output logic                                out_valid,
  output logic [stia_pkg::STATUS_W-1:0]       out_status,
  output logic                                out_found,
  output logic                                out_found_kind,
  output logic [stia_pkg::IDX_W-1:0]          out_register_index,
  output logic [stia_pkg::CNT_W-1:0]          out_qubit_count,
  output logic [stia_pkg::CNT_W-1:0]          out_classical_count
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WW = KEY_BITS + 1 + stia_pkg::IDX_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  stia_pkg::action_t       act_r;
  logic [KEY_BITS-1:0]     key_r;
  logic                    kind_r;
  logic [CW-1:0]           cnt_r, qcnt_r, ccnt_r, iss_r;
  logic                    pend_r;

  logic                    out_valid_r;
  stia_pkg::status_t       status_r;
  logic                    found_r, fkind_r;
  stia_pkg::idx_t          idx_r;
  stia_pkg::cnt_t          qout_r, cout_r;

  logic                    accept, in_scan, more, re, hit, miss, full, we, res_done;
  stia_pkg::action_t       in_act;
  logic [WW-1:0]           rdata, wdata;
  logic [KEY_BITS-1:0]     rd_key;
  stia_pkg::idx_t          rd_idx, new_idx;
  logic                    rd_kind;
  logic [CW-1:0]           q_after, c_after;

  stia_pkg::status_t       o_status;
  logic                    o_found, o_fkind;
  stia_pkg::idx_t          o_idx;
  stia_pkg::cnt_t          o_q, o_c;

  // handshake and scan control
  assign in_act  = stia_pkg::action_t'(in_action);
  assign busy    = (state_r == S_SCAN);
  assign accept  = start && !busy;
  assign in_scan = (state_r == S_SCAN);
  assign more    = (iss_r < cnt_r);
  assign re      = in_scan && more;

  // read data fields
  assign rd_key  = rdata[KEY_BITS-1:0];
  assign rd_idx  = rdata[KEY_BITS +: stia_pkg::IDX_W];
  assign rd_kind = rdata[WW-1];

  // compare the entry read last cycle, or finish when nothing is left
  assign hit  = in_scan && pend_r && (rd_key == key_r);
  assign miss = in_scan && !pend_r && !more;
  assign full = (cnt_r >= CW'(ENTRIES));
  assign we   = miss && (act_r == stia_pkg::ACT_DECLARE) && !full;

  assign new_idx = kind_r ? stia_pkg::idx_t'(qcnt_r) : stia_pkg::idx_t'(ccnt_r);
  assign wdata   = {kind_r, new_idx, key_r};
  assign q_after = qcnt_r + CW'(we && kind_r);
  assign c_after = ccnt_r + CW'(we && !kind_r);

  assign res_done = (accept && (in_act == stia_pkg::ACT_CLEAR || in_act == stia_pkg::ACT_NOP))
                    || hit || miss;

  stia_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (WW),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (wdata),
    .re    (re),
    .raddr (iss_r[AW-1:0]),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_act == stia_pkg::ACT_DECLARE || in_act == stia_pkg::ACT_QUERY)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || miss) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      qcnt_r      <= '0;
      ccnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= re;
      out_valid_r <= res_done;
      if (accept && in_act == stia_pkg::ACT_CLEAR) begin
        cnt_r  <= '0;
        qcnt_r <= '0;
        ccnt_r <= '0;
      end else if (we) begin
        cnt_r  <= cnt_r + CW'(1);
        qcnt_r <= q_after;
        ccnt_r <= c_after;
      end
    end
  end

  // transaction capture and scan pointer
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_act;
      key_r  <= in_name_key[KEY_BITS-1:0];
      kind_r <= in_kind;
      iss_r  <= '0;
    end else if (re) begin
      iss_r  <= iss_r + CW'(1);
    end
  end

  // result fields
  always_comb begin
    o_status = stia_pkg::ST_OK;
    o_found  = 1'b0;
    o_fkind  = 1'b0;
    o_idx    = '0;
    o_q      = stia_pkg::cnt_t'(q_after);
    o_c      = stia_pkg::cnt_t'(c_after);
    priority if (accept) begin
      if (in_act == stia_pkg::ACT_CLEAR) begin
        o_q = '0;
        o_c = '0;
      end
    end else if (hit) begin
      o_found = 1'b1;
      o_fkind = rd_kind;
      o_idx   = rd_idx;
      if (act_r == stia_pkg::ACT_DECLARE) begin
        o_status = stia_pkg::ST_DUPLICATE;
      end else if (rd_kind != kind_r) begin
        o_status = stia_pkg::ST_WRONG_KIND;
      end
    end else begin
      if (act_r == stia_pkg::ACT_QUERY) begin
        o_status = stia_pkg::ST_UNDECLARED;
      end else if (full) begin
        o_status = stia_pkg::ST_FULL;
      end else begin
        o_fkind = kind_r;
        o_idx   = new_idx;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (res_done) begin
      status_r <= o_status;
      found_r  <= o_found;
      fkind_r  <= o_fkind;
      idx_r    <= o_idx;
      qout_r   <= o_q;
      cout_r   <= o_c;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_found           = found_r;
  assign out_found_kind      = fkind_r;
  assign out_register_index  = idx_r;
  assign out_qubit_count     = qout_r;
  assign out_classical_count = cout_r;

endmodule

`default_nettype wire

// ===== hw/rtl/stia_mem.sv =====
// ----------------------------------------------------------------------------
// stia_mem
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stia_mem #(
  parameter int DEPTH = stia_pkg::ENTRIES_DEF,
  parameter int WIDTH = stia_pkg::KEY_BITS_DEF + 1 + stia_pkg::IDX_W,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/stia_chk.sv =====
// ----------------------------------------------------------------------------
// stia_chk
// Port-level checks of the symbol table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stia_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [stia_pkg::ACT_W-1:0]    in_action,
  input wire logic                          out_valid,
  input wire logic [stia_pkg::STATUS_W-1:0] out_status,
  input wire logic                          out_found,
  input wire logic [stia_pkg::CNT_W-1:0]    out_qubit_count,
  input wire logic [stia_pkg::CNT_W-1:0]    out_classical_count
);

  // an accepted transaction either answers at once or starts a scan
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted transaction neither answered nor scanning");

  // a result never coexists with a running scan
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // clear empties both counts
  a_clear_counts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action == stia_pkg::ACT_CLEAR |=>
      out_valid && out_status == stia_pkg::ST_OK &&
      out_qubit_count == '0 && out_classical_count == '0)
    else $error("clear did not empty the counts");

  // found flag agrees with the status
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == stia_pkg::ST_DUPLICATE ||
                  out_status == stia_pkg::ST_WRONG_KIND) |-> out_found)
    else $error("duplicate or wrong kind without found");

  a_notfound_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == stia_pkg::ST_FULL ||
                  out_status == stia_pkg::ST_UNDECLARED) |-> !out_found)
    else $error("full or undeclared with found set");

endmodule

bind symbol_table_with_index_allocation stia_chk u_stia_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_action           (in_action),
  .out_valid           (out_valid),
  .out_status          (out_status),
  .out_found           (out_found),
  .out_qubit_count     (out_qubit_count),
  .out_classical_count (out_classical_count)
);

`default_nettype wire

// ===== tb/sv/symbol_table_with_index_allocation_tb.sv =====
// ----------------------------------------------------------------------------
// symbol_table_with_index_allocation_tb
// Self-checking bench for the symbol table with per-kind index allocation.
// Drives clear, declare, query and the unused action through the start/busy
// handshake in random bursts. A local model of the table predicts every
// result, and each strobed result is checked field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module symbol_table_with_index_allocation_tb;

  import stia_pkg::*;

  localparam int TOTAL_OPS    = 550;
  localparam int DRAIN_CYCLES = 100;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    status_t    status;
    logic       found;
    logic       found_kind;
    idx_t       reg_index;
    cnt_t       qubits;
    cnt_t       clbits;
  } symbol_result_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [ACT_W-1:0]    in_action;
  logic [KEY_W-1:0]    in_name_key;
  logic                in_kind;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_found;
  logic                out_found_kind;
  logic [IDX_W-1:0]    out_register_index;
  logic [CNT_W-1:0]    out_qubit_count;
  logic [CNT_W-1:0]    out_classical_count;

  // model of the table contents and counters
  logic [KEY_W-1:0]    name_tab [ENTRIES_DEF];
  logic                kind_tab [ENTRIES_DEF];
  idx_t                idx_tab  [ENTRIES_DEF];
  int                  live_entries;
  int                  qubit_total;
  int                  clbit_total;

  symbol_result_t      pending_results[$];
  symbol_result_t      want;
  logic [KEY_W-1:0]    session_names[$];
  int                  accepted_ops;
  int                  sent_ops;
  int                  fail_count;
  int                  burst_left;

  symbol_table_with_index_allocation dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_name_key         (in_name_key),
    .in_kind             (in_kind),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_found           (out_found),
    .out_found_kind      (out_found_kind),
    .out_register_index  (out_register_index),
    .out_qubit_count     (out_qubit_count),
    .out_classical_count (out_classical_count)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // apply one transaction to the model table and return its result
  function automatic symbol_result_t apply_symbol_op(action_t act, logic [KEY_W-1:0] key,
                                                     logic knd);
    symbol_result_t r;
    int slot;
    r = '0;
    r.status = ST_OK;
    slot = -1;
    if (act == ACT_DECLARE || act == ACT_QUERY) begin
      for (int i = 0; i < live_entries; i++) begin
        if (slot < 0 && name_tab[i] == key) slot = i;
      end
    end
    case (act)
      ACT_CLEAR: begin
        live_entries = 0;
        qubit_total  = 0;
        clbit_total  = 0;
      end
      ACT_DECLARE: begin
        if (slot >= 0) begin
          r.status     = ST_DUPLICATE;
          r.found      = 1'b1;
          r.found_kind = kind_tab[slot];
          r.reg_index  = idx_tab[slot];
        end else if (live_entries >= ENTRIES_DEF) begin
          r.status = ST_FULL;
        end else begin
          // next index of this kind, reported in 6 bits
          if (knd) begin
            r.reg_index = idx_t'(qubit_total);
            qubit_total++;
          end else begin
            r.reg_index = idx_t'(clbit_total);
            clbit_total++;
          end
          name_tab[live_entries] = key;
          kind_tab[live_entries] = knd;
          idx_tab[live_entries]  = r.reg_index;
          r.found_kind = knd;
          live_entries++;
        end
      end
      ACT_QUERY: begin
        if (slot < 0) begin
          r.status = ST_UNDECLARED;
        end else begin
          r.found      = 1'b1;
          r.found_kind = kind_tab[slot];
          r.reg_index  = idx_tab[slot];
          if (kind_tab[slot] != knd) r.status = ST_WRONG_KIND;
        end
      end
      default: ;
    endcase
    r.qubits = cnt_t'(qubit_total);
    r.clbits = cnt_t'(clbit_total);
    return r;
  endfunction

  function automatic void note_mismatch(string field, longint exp_val, longint got_val);
    fail_count++;
    if (fail_count <= SHOWN_ERRORS)
      $display("mismatch on %s: expected %0d, got %0d", field, exp_val, got_val);
  endfunction

  // result checking and prediction of each accepted transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOWN_ERRORS)
            $display("unexpected result with status %0d", out_status);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            note_mismatch("status", longint'(want.status), longint'(out_status));
          if (out_found !== want.found)
            note_mismatch("found", longint'(want.found), longint'(out_found));
          if (out_found_kind !== want.found_kind)
            note_mismatch("found_kind", longint'(want.found_kind),
                          longint'(out_found_kind));
          if (out_register_index !== want.reg_index)
            note_mismatch("register_index", longint'(want.reg_index),
                          longint'(out_register_index));
          if (out_qubit_count !== want.qubits)
            note_mismatch("qubit_count", longint'(want.qubits),
                          longint'(out_qubit_count));
          if (out_classical_count !== want.clbits)
            note_mismatch("classical_count", longint'(want.clbits),
                          longint'(out_classical_count));
        end
      end
      if (start && !busy) begin
        pending_results.push_back(apply_symbol_op(action_t'(in_action), in_name_key, in_kind));
        accepted_ops++;
      end
    end
  end

  // send one transaction, starting and ending at a falling edge, then pace bursts
  task automatic issue_op(input action_t act, input logic [KEY_W-1:0] key, input logic knd);
    int taken;
    int gap;
    taken       = accepted_ops;
    start       = 1'b1;
    in_action   = act;
    in_name_key = key;
    in_kind     = knd;
    do @(negedge clk); while (accepted_ops == taken);
    sent_ops++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        // idle gap with junk on the fields
        gap         = $urandom_range(1, 9);
        start       = 1'b0;
        in_action   = ACT_W'($urandom);
        in_name_key = {$urandom, $urandom};
        in_kind     = 1'($urandom_range(0, 1));
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // random name, sometimes from a tiny range so collisions happen
  function automatic logic [KEY_W-1:0] fresh_name();
    case ($urandom_range(0, 7))
      0: return KEY_W'($urandom_range(0, 15));
      1: return ~KEY_W'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] known_or_fresh();
    if (session_names.size() > 0 && $urandom_range(0, 4) != 0)
      return session_names[$urandom_range(0, session_names.size() - 1)];
    return fresh_name();
  endfunction

  // extremes of the fields and every status except full
  task automatic test_directed_cases();
    issue_op(ACT_CLEAR, '1, 1'b1);
    issue_op(ACT_QUERY, '0, 1'b0);
    issue_op(ACT_DECLARE, '0, 1'b0);
    issue_op(ACT_DECLARE, '1, 1'b1);
    issue_op(ACT_DECLARE, 64'h8000_0000_0000_0000, 1'b1);
    issue_op(ACT_DECLARE, 64'h1, 1'b0);
    issue_op(ACT_DECLARE, '1, 1'b0);
    issue_op(ACT_QUERY, '0, 1'b0);
    issue_op(ACT_QUERY, '0, 1'b1);
    issue_op(ACT_QUERY, '1, 1'b1);
    issue_op(ACT_QUERY, 64'h5555_5555_5555_5555, 1'b1);
    issue_op(ACT_NOP, '1, 1'b1);
    issue_op(ACT_DECLARE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    issue_op(ACT_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    issue_op(ACT_QUERY, 64'h8000_0000_0000_0000, 1'b1);
    issue_op(ACT_CLEAR, '0, 1'b0);
    issue_op(ACT_QUERY, '1, 1'b1);
    issue_op(ACT_DECLARE, '1, 1'b0);
    issue_op(ACT_NOP, '0, 1'b0);
  endtask

  // fill all entries with one kind, then hit the full table paths
  task automatic test_full_table(input logic fill_kind);
    logic [KEY_W-1:0] first_name;
    logic [KEY_W-1:0] last_name;
    issue_op(ACT_CLEAR, fresh_name(), 1'($urandom_range(0, 1)));
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      last_name = {$urandom, $urandom};
      if (i == 0) first_name = last_name;
      issue_op(ACT_DECLARE, last_name, fill_kind);
    end
    issue_op(ACT_DECLARE, {$urandom, $urandom}, ~fill_kind);
    issue_op(ACT_DECLARE, last_name, ~fill_kind);
    issue_op(ACT_QUERY, last_name, fill_kind);
    issue_op(ACT_QUERY, first_name, ~fill_kind);
    issue_op(ACT_QUERY, {$urandom, $urandom}, fill_kind);
    issue_op(ACT_NOP, last_name, fill_kind);
  endtask

  // sessions of random length opened by a clear, a few of them filling the table
  task automatic test_random_sessions();
    int target;
    int ops;
    int pick;
    int new_pct;
    logic [KEY_W-1:0] key;
    while (sent_ops < TOTAL_OPS) begin
      session_names.delete();
      issue_op(ACT_CLEAR, fresh_name(), 1'($urandom_range(0, 1)));
      target  = ($urandom_range(0, 5) == 0) ? ENTRIES_DEF + 6 : $urandom_range(1, 24);
      new_pct = (target > ENTRIES_DEF) ? 65 : 30;
      ops     = (target > ENTRIES_DEF) ? 130 : $urandom_range(target, 2 * target + 4);
      repeat (ops) begin
        if (sent_ops >= TOTAL_OPS) break;
        pick = $urandom_range(0, 99);
        if (pick < new_pct) begin
          key = fresh_name();
          session_names.push_back(key);
          issue_op(ACT_DECLARE, key, 1'($urandom_range(0, 1)));
        end else if (pick < new_pct + 10) begin
          issue_op(ACT_DECLARE, known_or_fresh(), 1'($urandom_range(0, 1)));
        end else if (pick < 93) begin
          issue_op(ACT_QUERY, known_or_fresh(), 1'($urandom_range(0, 1)));
        end else if (pick < 98) begin
          issue_op(ACT_NOP, fresh_name(), 1'($urandom_range(0, 1)));
        end else begin
          // clear in the middle of a session
          session_names.delete();
          issue_op(ACT_CLEAR, known_or_fresh(), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  // reset, tests, drain and final verdict
  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_action    = ACT_CLEAR;
    in_name_key  = '0;
    in_kind      = 1'b0;
    live_entries = 0;
    qubit_total  = 0;
    clbit_total  = 0;
    accepted_ops = 0;
    sent_ops     = 0;
    fail_count   = 0;
    burst_left   = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    test_directed_cases();
    test_full_table(1'b1);
    test_full_table(1'b0);
    test_random_sessions();

    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/stia_pkg.sv
hw/rtl/stia_mem.sv
hw/rtl/symbol_table_with_index_allocation.sv
hw/rtl/stia_chk.sv
tb/sv/symbol_table_with_index_allocation_tb.sv
